// ===== design/mbd_pkg.sv =====
// Package for the multi-button debounce and press timer.
// Holds sizes, register indexes, the structs passed between modules and the schedule lookup.
// No dependencies; every other design file imports it.
package mbd_pkg;

	// lane and field sizes
	localparam int BUTTONS    = 8;
	localparam int BEEP_STEPS = 4;
	localparam int LANE_W     = $clog2(BUTTONS);
	localparam int LEVEL_W    = 8;
	localparam int MS_W       = 16;
	localparam int PRESS_W    = 32;
	localparam int SINCE_W    = 17;
	localparam int STEP_W     = 3;
	localparam int BCOUNT_W   = 4;
	localparam int TIMES_W    = MS_W * BEEP_STEPS;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;

	localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};
	localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};
	localparam logic [MS_W-1:0]    MS_MAX    = {MS_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_DUR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_TIMES   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT = 3'd6;

	// shared settings seen by every lane
	typedef struct packed {
		logic [MS_W-1:0]    debounce;
		logic [MS_W-1:0]    min_press;
		logic [STEP_W-1:0]  steps;
		logic [TIMES_W-1:0] beep_times;
	} lane_ctl_t;

	// per-lane flags for the current tick
	typedef struct packed {
		logic evt;
		logic trig;
	} lane_flag_t;

	// hold time of one schedule entry
	function automatic logic [MS_W-1:0] schedule_entry(input logic [TIMES_W-1:0] times,
			input logic [STEP_W-1:0] step);
		logic [MS_W-1:0] entry;
		entry = '0;
		for (int k = 0; k < BEEP_STEPS; k++) begin
			if (step == STEP_W'(k)) begin
				entry = times[k*MS_W +: MS_W];
			end
		end
		return entry;
	endfunction

endpackage

// ===== design/mbd_lane.sv =====
// One button lane: debounce counter, stable level, press timer and beep schedule step.
// Depends on mbd_pkg.
module mbd_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic                        in_use,
	input  logic                        raw_bit,
	input  logic                        act_bit,
	input  mbd_pkg::lane_ctl_t          ctl,
	output mbd_pkg::lane_flag_t         flag,
	output logic [mbd_pkg::PRESS_W-1:0] press_time
);
	import mbd_pkg::*;

	logic               stable_q;
	logic               rawprev_q;
	logic [SINCE_W-1:0] since_q;
	logic [PRESS_W-1:0] press_q;
	logic [STEP_W-1:0]  step_q;

	logic               pressed;
	logic               stable_n;
	logic [SINCE_W-1:0] since_n;
	logic [PRESS_W-1:0] press_inc;
	logic [PRESS_W-1:0] press_n;
	logic [STEP_W-1:0]  step_n;
	logic               trig;
	logic               evt;

	// next lane state for this tick
	always_comb begin
		pressed   = (raw_bit == act_bit);
		press_inc = (press_q != PRESS_MAX) ? press_q + 1'b1 : press_q;
		press_n   = press_inc;
		stable_n  = stable_q;
		step_n    = step_q;
		trig      = 1'b0;
		evt       = 1'b0;
		if (pressed != rawprev_q) begin
			since_n = '0;
		end else if (since_q != SINCE_MAX) begin
			since_n = since_q + 1'b1;
		end else begin
			since_n = since_q;
		end
		if (since_n > {1'b0, ctl.debounce}) begin
			// beep schedule while held
			if (stable_q && (ctl.steps != '0) && (step_q < ctl.steps) &&
				(press_inc >= {{(PRESS_W-MS_W){1'b0}},
					schedule_entry(ctl.beep_times, step_q)})) begin
				trig   = 1'b1;
				step_n = step_q + 1'b1;
			end
			// debounced level change
			if (pressed != stable_q) begin
				stable_n = pressed;
				if (pressed) begin
					press_n = '0;
					step_n  = '0;
				end else if (press_inc >= {{(PRESS_W-MS_W){1'b0}}, ctl.min_press}) begin
					evt = 1'b1;
				end
			end
		end
	end

	assign flag.evt   = evt && in_use;
	assign flag.trig  = trig && in_use;
	assign press_time = press_inc;

	// lane state, frozen while the lane is out of use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q  <= 1'b0;
			rawprev_q <= 1'b0;
			since_q   <= '0;
			press_q   <= '0;
			step_q    <= '0;
		end else if (take && in_use) begin
			stable_q  <= stable_n;
			rawprev_q <= pressed;
			since_q   <= since_n;
			press_q   <= press_n;
			step_q    <= step_n;
		end
	end

endmodule

// ===== design/mbd_beep.sv =====
// Shared beep timer: falls after the beep duration, restarts on any lane trigger.
// Depends on mbd_pkg.
module mbd_beep (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic                     any_trig,
	input  logic [mbd_pkg::MS_W-1:0] duration,
	output logic                     beep_next
);
	import mbd_pkg::*;

	logic            active_q;
	logic [MS_W-1:0] elapsed_q;
	logic            active_n;
	logic [MS_W-1:0] elapsed_n;

	// advance the running beep, then apply a new trigger
	always_comb begin
		active_n  = active_q;
		elapsed_n = elapsed_q;
		if (active_q) begin
			if (elapsed_q != MS_MAX) begin
				elapsed_n = elapsed_q + 1'b1;
			end
			if (elapsed_n >= duration) begin
				active_n = 1'b0;
			end
		end
		if (any_trig) begin
			active_n  = 1'b1;
			elapsed_n = '0;
		end
	end

	assign beep_next = active_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			elapsed_q <= '0;
		end else if (take) begin
			active_q  <= active_n;
			elapsed_q <= elapsed_n;
		end
	end

endmodule

// ===== design/mbd_out.sv =====
// Result register: holds the release events of one tick and hands them out one beat each.
// Depends on mbd_pkg.
module mbd_out (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         load,
	input  logic [mbd_pkg::BUTTONS-1:0]                  evt_mask,
	input  logic [mbd_pkg::BUTTONS-1:0][mbd_pkg::PRESS_W-1:0] evt_time,
	input  logic                                         beep_in,
	output logic                                         room,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic                                         event_valid,
	output logic [2:0]                                   button_index,
	output logic [31:0]                                  press_ms,
	output logic                                         beep_on,
	output logic                                         last
);
	import mbd_pkg::*;

	logic                             valid_q;
	logic [BUTTONS-1:0]               mask_q;
	logic [BUTTONS-1:0][PRESS_W-1:0]  time_q;
	logic                             beep_q;

	logic [LANE_W-1:0]  idx;
	logic [BUTTONS-1:0] rest;
	logic               take_out;

	// lowest pending lane
	always_comb begin
		idx = '0;
		for (int j = BUTTONS - 1; j >= 0; j--) begin
			if (mask_q[j]) begin
				idx = LANE_W'(j);
			end
		end
	end

	assign rest         = mask_q & (mask_q - 1'b1);
	assign out_valid    = valid_q;
	assign event_valid  = (mask_q != '0);
	assign button_index = event_valid ? 3'(idx) : 3'd0;
	assign press_ms     = event_valid ? time_q[idx] : 32'd0;
	assign beep_on      = beep_q;
	assign last         = (rest == '0);
	assign take_out     = valid_q && !out_stall;
	assign room         = !valid_q || (take_out && last);

	// control: valid flag and pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mask_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			mask_q  <= evt_mask;
		end else if (take_out) begin
			if (last) begin
				valid_q <= 1'b0;
			end
			mask_q <= rest;
		end
	end

	// payload captured with the tick
	always_ff @(posedge clk) begin
		if (load) begin
			time_q <= evt_time;
			beep_q <= beep_in;
		end
	end

	// a freshly accepted tick always shows up as a beat
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("accepted tick did not produce a result beat");

	// a tick without releases is a single beat
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !event_valid) |-> last)
		else $error("no-event beat not marked last");

	// events of one tick leave in rising lane order
	a_lane_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_valid && !last && !out_stall) |=>
			(out_valid && event_valid && (button_index > $past(button_index))))
		else $error("release events out of lane order");

	// no new tick while earlier events still wait
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> !load)
		else $error("tick loaded over pending events");

endmodule

// ===== design/multi_button_debounce_press_timer.sv =====
// Top level of the multi-button debounce and press timer.
// Depends on mbd_pkg, mbd_lane, mbd_beep and mbd_out.
//
// Each accepted beat on the input is one millisecond tick with the raw levels of all
// buttons. The lanes and the beep timer update in the cycle the tick is accepted and the
// results land in the result register; ticks with no release or one release can follow
// back to back while the output is not stalled. A tick with n debounced releases
// (n up to 8) holds the result register for n beats, one per release in lane order; the
// next tick is accepted in the cycle the last of them is taken. Configuration writes are
// plain indexed writes and take effect on the next tick.
module multi_button_debounce_press_timer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     button_levels,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           event_valid,
	output logic [2:0]                     button_index,
	output logic [31:0]                    press_ms,
	output logic                           beep_on,
	output logic                           last
);
	import mbd_pkg::*;

	logic [MS_W-1:0]     debounce_q;
	logic [MS_W-1:0]     min_press_q;
	logic [MS_W-1:0]     beep_dur_q;
	logic [STEP_W-1:0]   beep_count_q;
	logic [TIMES_W-1:0]  beep_times_q;
	logic [LEVEL_W-1:0]  active_q;
	logic [BCOUNT_W-1:0] button_count_q;

	lane_ctl_t                       ctl;
	lane_flag_t [BUTTONS-1:0]        flags;
	logic [BUTTONS-1:0][PRESS_W-1:0] times;
	logic [BUTTONS-1:0]              evt_mask;
	logic [BUTTONS-1:0]              trig_mask;
	logic                            room;
	logic                            take;
	logic                            beep_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= 16'd50;
			min_press_q    <= 16'd50;
			beep_dur_q     <= 16'd100;
			beep_count_q   <= '0;
			beep_times_q   <= '0;
			active_q       <= '0;
			button_count_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEBOUNCE:     debounce_q     <= cfg_data[MS_W-1:0];
				REG_MIN_PRESS:    min_press_q    <= cfg_data[MS_W-1:0];
				REG_BEEP_DUR:     beep_dur_q     <= cfg_data[MS_W-1:0];
				REG_BEEP_COUNT:   beep_count_q   <= cfg_data[STEP_W-1:0];
				REG_BEEP_TIMES:   beep_times_q   <= cfg_data[TIMES_W-1:0];
				REG_ACTIVE:       active_q       <= cfg_data[LEVEL_W-1:0];
				REG_BUTTON_COUNT: button_count_q <= cfg_data[BCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// shared lane settings, schedule length clamped to the table size
	assign ctl.debounce   = debounce_q;
	assign ctl.min_press  = min_press_q;
	assign ctl.steps      = (beep_count_q > STEP_W'(BEEP_STEPS)) ? STEP_W'(BEEP_STEPS)
		: beep_count_q;
	assign ctl.beep_times = beep_times_q;

	assign take     = in_valid && room;
	assign in_stall = !room;

	// button lanes
	for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
		logic raw_bit;
		logic act_bit;
		logic in_use;

		if (i < LEVEL_W) begin : g_bits
			assign raw_bit = button_levels[i];
			assign act_bit = active_q[i];
		end else begin : g_zero
			assign raw_bit = 1'b0;
			assign act_bit = 1'b0;
		end

		assign in_use       = (BCOUNT_W'(i) < button_count_q);
		assign evt_mask[i]  = flags[i].evt;
		assign trig_mask[i] = flags[i].trig;

		mbd_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.take       (take),
			.in_use     (in_use),
			.raw_bit    (raw_bit),
			.act_bit    (act_bit),
			.ctl        (ctl),
			.flag       (flags[i]),
			.press_time (times[i])
		);
	end

	// shared beep output
	mbd_beep u_beep (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.any_trig  (trig_mask != '0),
		.duration  (beep_dur_q),
		.beep_next (beep_next)
	);

	// result register and event serializer
	mbd_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (take),
		.evt_mask     (evt_mask),
		.evt_time     (times),
		.beep_in      (beep_next),
		.room         (room),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_valid  (event_valid),
		.button_index (button_index),
		.press_ms     (press_ms),
		.beep_on      (beep_on),
		.last         (last)
	);

endmodule

// ===== test/mbd_checker.sv =====
// Checker for the multi-button debounce and press timer: mirrors the register writes,
// predicts the results of every accepted tick beat and compares them with the output beats.
// Depends on mbd_pkg for sizes and register indexes.
module mbd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [7:0]                    button_levels,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          event_valid,
	input  logic [2:0]                    button_index,
	input  logic [31:0]                   press_ms,
	input  logic                          beep_on,
	input  logic                          last,
	output int                            errors,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mbd_pkg::*;

	typedef struct packed {
		logic               evt;
		logic [2:0]         lane;
		logic [PRESS_W-1:0] held_ms;
		logic               beep;
		logic               fin;
	} release_t;

	// register copies
	logic [MS_W-1:0]     debounce_cfg;
	logic [MS_W-1:0]     min_press_cfg;
	logic [MS_W-1:0]     beep_dur_cfg;
	logic [STEP_W-1:0]   beep_count_cfg;
	logic [TIMES_W-1:0]  beep_times_cfg;
	logic [LEVEL_W-1:0]  active_cfg;
	logic [BCOUNT_W-1:0] button_count_cfg;

	// per-lane debounce and press state, kept as pressed flags
	logic [BUTTONS-1:0] stable_pressed;
	logic [BUTTONS-1:0] raw_pressed;
	logic [SINCE_W-1:0] since_flip [BUTTONS];
	logic [PRESS_W-1:0] held_count [BUTTONS];
	logic [STEP_W-1:0]  next_beep [BUTTONS];
	logic               buzzer;
	logic [MS_W-1:0]    buzz_age;

	release_t release_q[$];

	// advance the lane state by one tick and queue the results it gives
	function automatic void advance_tick(input logic [LEVEL_W-1:0] levels);
		int lanes;
		int steps;
		int found;
		logic pressed;
		logic [MS_W-1:0] hold_mark;
		logic [2:0] ev_lane [8];
		logic [PRESS_W-1:0] ev_ms [8];
		lanes = (button_count_cfg > BUTTONS) ? BUTTONS : int'(button_count_cfg);
		steps = (beep_count_cfg > BEEP_STEPS) ? BEEP_STEPS : int'(beep_count_cfg);
		found = 0;

		// beep timer runs first
		if (buzzer) begin
			if (buzz_age != MS_MAX)
				buzz_age++;
			if (buzz_age >= beep_dur_cfg)
				buzzer = 1'b0;
		end

		for (int i = 0; i < lanes; i++) begin
			pressed = (levels[i] == active_cfg[i]);
			if (held_count[i] != PRESS_MAX)
				held_count[i]++;
			if (pressed != raw_pressed[i]) begin
				raw_pressed[i] = pressed;
				since_flip[i] = '0;
			end else if (since_flip[i] != SINCE_MAX) begin
				since_flip[i]++;
			end
			if (since_flip[i] > {1'b0, debounce_cfg}) begin
				// beep when a held lane reaches its next schedule mark
				if (stable_pressed[i] && int'(next_beep[i]) < steps) begin
					hold_mark = beep_times_cfg[int'(next_beep[i]) * MS_W +: MS_W];
					if (held_count[i] >= {16'd0, hold_mark}) begin
						buzzer = 1'b1;
						buzz_age = '0;
						next_beep[i]++;
					end
				end
				// adopt the settled level
				if (pressed != stable_pressed[i]) begin
					stable_pressed[i] = pressed;
					if (pressed) begin
						held_count[i] = '0;
						next_beep[i] = '0;
					end else if (held_count[i] >= {16'd0, min_press_cfg} && found < 8) begin
						ev_lane[found] = 3'(i);
						ev_ms[found] = held_count[i];
						found++;
					end
				end
			end
		end

		if (found == 0)
			release_q.push_back('{1'b0, 3'd0, '0, buzzer, 1'b1});
		for (int k = 0; k < found; k++)
			release_q.push_back('{1'b1, ev_lane[k], ev_ms[k], buzzer, k == found - 1});
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
		end
	endfunction

	// watch the register port and both channels
	always @(posedge clk or negedge arst_n) begin
		release_t want;
		if (!arst_n) begin
			debounce_cfg     = 16'd50;
			min_press_cfg    = 16'd50;
			beep_dur_cfg     = 16'd100;
			beep_count_cfg   = '0;
			beep_times_cfg   = '0;
			active_cfg       = '0;
			button_count_cfg = '0;
			stable_pressed   = '0;
			raw_pressed      = '0;
			for (int i = 0; i < BUTTONS; i++) begin
				since_flip[i] = '0;
				held_count[i] = '0;
				next_beep[i]  = '0;
			end
			buzzer   = 1'b0;
			buzz_age = '0;
			release_q.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_DEBOUNCE:     debounce_cfg     = cfg_data[MS_W-1:0];
					REG_MIN_PRESS:    min_press_cfg    = cfg_data[MS_W-1:0];
					REG_BEEP_DUR:     beep_dur_cfg     = cfg_data[MS_W-1:0];
					REG_BEEP_COUNT:   beep_count_cfg   = cfg_data[STEP_W-1:0];
					REG_BEEP_TIMES:   beep_times_cfg   = cfg_data[TIMES_W-1:0];
					REG_ACTIVE:       active_cfg       = cfg_data[LEVEL_W-1:0];
					REG_BUTTON_COUNT: button_count_cfg = cfg_data[BCOUNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				advance_tick(button_levels);
			if (out_valid && !out_stall) begin
				if (release_q.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected: event %0b lane %0d ms %0d beep %0b last %0b",
						$time, event_valid, button_index, press_ms, beep_on, last);
				end else begin
					want = release_q.pop_front();
					check_field("event_valid", 32'(want.evt), 32'(event_valid));
					check_field("button_index", 32'(want.lane), 32'(button_index));
					check_field("press_ms", want.held_ms, press_ms);
					check_field("beep_on", 32'(want.beep), 32'(beep_on));
					check_field("last", 32'(want.fin), 32'(last));
				end
			end
		end
		pending = release_q.size();
	end

endmodule

// ===== test/testbench.sv =====
// Top of the debounce and press timer test: clock, reset, register setup, tick beats and
// output stalls, plus the final verdict. Depends on mbd_pkg, the block and mbd_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mbd_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 500000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           button_levels = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 event_valid;
	logic [2:0]           button_index;
	logic [31:0]          press_ms;
	logic                 beep_on;
	logic                 last;
	int                   errors;
	int                   pending;

	bit          hold_request;
	int          cycle_count;
	int          burst_left;
	int          hold_span = 4;
	int          lane_hold [8];
	logic [7:0]  lane_level = '0;
	logic [7:0]  directed_ticks [20] = '{
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h0F,
		8'h0F, 8'h0F, 8'hF0, 8'hF0, 8'hF0, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00
	};

	multi_button_debounce_press_timer DUT (.*);
	mbd_checker release_check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stalls: random patterns, clean stretches and one long hold-off on request
	initial begin
		int pat_mode;
		int pat_left;
		pat_mode = 0;
		pat_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(posedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else begin
				if (pat_left == 0) begin
					pat_mode = $urandom_range(0, 3);
					pat_left = $urandom_range(10, 80);
				end
				pat_left--;
				case (pat_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 1);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// one tick beat, sent in bursts with random gaps
	task automatic send_tick(input logic [7:0] levels);
		int gap;
		logic taken;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		button_levels <= levels;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// stop sending and wait for every expected beat
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// write every register once the block is idle
	task automatic configure(input logic [15:0] deb, input logic [15:0] min_ms,
			input logic [15:0] dur, input logic [2:0] bcnt, input logic [63:0] times,
			input logic [7:0] act, input logic [3:0] nbtn);
		wait_idle();
		write_reg(REG_DEBOUNCE, CFG_W'(deb));
		write_reg(REG_MIN_PRESS, CFG_W'(min_ms));
		write_reg(REG_BEEP_DUR, CFG_W'(dur));
		write_reg(REG_BEEP_COUNT, CFG_W'(bcnt));
		write_reg(REG_BEEP_TIMES, CFG_W'(times));
		write_reg(REG_ACTIVE, CFG_W'(act));
		write_reg(REG_BUTTON_COUNT, CFG_W'(nbtn));
		cfg_write <= 1'b0;
		// hold times scale with the settings so presses get past debounce
		hold_span = 2 * ((deb > 12) ? 12 : int'(deb)) + ((min_ms > 12) ? 12 : int'(min_ms)) + 4;
	endtask

	function automatic logic [63:0] random_times(input int unsigned top_ms);
		logic [63:0] t;
		for (int k = 0; k < 4; k++)
			t[k*16 +: 16] = 16'($urandom_range(0, top_ms));
		return t;
	endfunction

	// mostly clean press and release sequences, with glitches and junk ticks
	task automatic random_ticks(input int count);
		logic [7:0] levels;
		int pick;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 8; i++) begin
				if (lane_hold[i] == 0) begin
					lane_level[i] = ~lane_level[i];
					lane_hold[i] = $urandom_range(1, hold_span);
				end else begin
					lane_hold[i]--;
				end
			end
			// all lanes flip together now and then
			if ($urandom_range(0, 24) == 0)
				lane_level = ~lane_level;
			levels = lane_level;
			case ($urandom_range(0, 19))
				0: levels = 8'($urandom_range(0, 255));
				1, 2: begin
					pick = $urandom_range(0, 7);
					levels[pick] = ~levels[pick];
				end
				default: ;
			endcase
			send_tick(levels);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all lanes at once, split groups, a single-tick glitch
		configure(16'd0, 16'd0, 16'd0, 3'd4, 64'h0003_0002_0001_0000, 8'hFF, 4'd8);
		foreach (directed_ticks[k])
			send_tick(directed_ticks[k]);

		configure(16'd2, 16'd3, 16'd4, 3'd3, random_times(20), 8'($urandom_range(0, 255)), 4'd8);
		random_ticks(90);
		configure(16'd0, 16'd0, 16'hFFFF, 3'd7, random_times(10), 8'h00, 4'd15);
		random_ticks(80);
		configure(16'hFFFF, 16'hFFFF, 16'd0, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 4'd8);
		random_ticks(30);

		// long receiver hold-off while ticks keep coming, then a full drain
		configure(16'd1, 16'd5, 16'd2, 3'd4, random_times(15), 8'($urandom_range(0, 255)),
			4'($urandom_range(1, 8)));
		random_ticks(40);
		hold_request = 1'b1;
		random_ticks(40);
		wait_idle();
		random_ticks(40);

		configure(16'd3, 16'd0, 16'd10, 3'd2, random_times(25), 8'h55, 4'd4);
		random_ticks(80);
		configure(16'($urandom_range(0, 4)), 16'($urandom_range(0, 10)),
			16'($urandom_range(0, 8)), 3'($urandom_range(0, 7)), random_times(30),
			8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
		random_ticks(100);
		configure(16'd0, 16'd1, 16'd1, 3'd4, random_times(8), 8'hAA, 4'd0);
		random_ticks(20);

		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
